### rtl/drrip_pkg.sv
// Shared types and constants for the DRRIP stream/dead-block replacement block.
`timescale 1ns / 1ps
package drrip_pkg;
	localparam int unsigned RRPV_TOP = 3;
	localparam int unsigned DEAD_TOP = 3;
	localparam int unsigned RUN_TOP  = 7;

	localparam logic CFG_STREAM_LENGTH  = 1'b0;
	localparam logic CFG_DEAD_THRESHOLD = 1'b1;

	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WRITE,
		BK_CLEAR
	} bk_state_t;
endpackage

### rtl/drrip_front.sv
// Front end: a two-entry queue of accepted transactions.
`timescale 1ns / 1ps
module drrip_front #(
	parameter int W = 38
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         q_valid,
	input  logic         q_pop,
	output logic [W-1:0] q_data
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### rtl/drrip_back.sv
// Back end: set metadata memories, read-modify-write sequencer and result register.
`timescale 1ns / 1ps
module drrip_back #(
	parameter int NUM_SETS    = 2048,
	parameter int NUM_WAYS    = 16,
	parameter int LEADER_SETS = 32,
	parameter int DUEL_WIDTH  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic        op,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic [15:0] addr_lsbs,
	input  logic        hit_flag,
	input  logic        victim_valid,
	input  logic [4:0]  random_draw,
	input  logic [2:0]  stream_len,
	input  logic [1:0]  dead_thr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  victim_way,
	output logic        streaming,
	output logic [9:0]  selector_value
);
	import drrip_pkg::*;

	localparam int SW = $clog2(NUM_SETS);
	localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int RW = 2 * NUM_WAYS;
	localparam int SRW = 35;
	localparam logic [DUEL_WIDTH-1:0] DMAX = {DUEL_WIDTH{1'b1}};

	logic [RW-1:0]  rrpv_mem  [NUM_SETS];
	logic [RW-1:0]  dead_mem  [NUM_SETS];
	logic [SRW-1:0] strm_mem  [NUM_SETS];

	bk_state_t state_q, state_d;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_w;
	logic [RW-1:0] rrpv_rd_q, dead_rd_q, rrpv_wr, dead_wr;
	logic [SRW-1:0] strm_rd_q, strm_wr;
	logic [DUEL_WIDTH-1:0] duel_q;
	logic ov_q;
	logic [3:0] vw_q;
	logic st_q;
	logic wr_en;

	assign set_w = set_index[SW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_q == SW'(NUM_SETS - 1)) state_d = BK_IDLE;
			BK_IDLE:  if (q_valid && (!ov_q || out_ready)) state_d = BK_READ;
			BK_READ:  state_d = BK_WRITE;
			BK_WRITE: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	assign q_pop = (state_q == BK_WRITE);
	assign wr_en = (state_q == BK_WRITE) || (state_q == BK_CLEAR);

	// compute new row contents from read data
	logic [1:0] top;
	logic [WW-1:0] vic;
	logic found;
	logic [15:0] paddr, pstride, stride;
	logic [2:0] run, nrun;
	logic st;
	logic [1:0] ins, cur_d, nd;
	logic leader_s, leader_b;
	logic [DUEL_WIDTH-1:0] duel_d;
	always_comb begin
		top = 2'd0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv_rd_q[2*w +: 2] > top) top = rrpv_rd_q[2*w +: 2];
		vic = '0;
		found = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (!found && rrpv_rd_q[2*w +: 2] == top) begin
				vic = WW'(w);
				found = 1'b1;
			end
		{run, pstride, paddr} = strm_rd_q;
		stride = addr_lsbs - paddr;
		st = 1'b0;
		nrun = run;
		if (run != 3'd0 && stride == pstride && stride != 16'd0) begin
			nrun = (run < 3'(RUN_TOP)) ? run + 3'd1 : run;
			st = (nrun >= stream_len);
			strm_wr = {nrun, pstride, addr_lsbs};
		end else begin
			strm_wr = {3'd1, stride, addr_lsbs};
		end
		leader_s = (32'(set_w) < 32'(LEADER_SETS / 2));
		leader_b = !leader_s && (32'(set_w) < 32'(LEADER_SETS));
		if (leader_s) ins = 2'd2;
		else if (leader_b || duel_q >= (DMAX >> 1)) ins = (random_draw == 5'd0) ? 2'd2 : 2'd3;
		else ins = 2'd2;
		rrpv_wr = rrpv_rd_q;
		dead_wr = dead_rd_q;
		duel_d = duel_q;
		cur_d = 2'd0;
		nd = 2'd0;
		if (op == OP_VICTIM) begin
			for (int w = 0; w < NUM_WAYS; w++)
				rrpv_wr[2*w +: 2] = rrpv_rd_q[2*w +: 2] + (2'(RRPV_TOP) - top);
		end else begin
			if (32'(way_index) < 32'(NUM_WAYS)) begin
				cur_d = dead_rd_q[2*way_index[WW-1:0] +: 2];
				if (!hit_flag) begin
					rrpv_wr[2*way_index[WW-1:0] +: 2] =
						(st || cur_d >= dead_thr) ? 2'(RRPV_TOP) : ins;
					nd = 2'd1;
				end else begin
					rrpv_wr[2*way_index[WW-1:0] +: 2] = 2'd0;
					nd = (cur_d != 2'd0) ? cur_d - 2'd1 : cur_d;
				end
				dead_wr[2*way_index[WW-1:0] +: 2] = nd;
			end
			if (!hit_flag && victim_valid)
				for (int w = 0; w < NUM_WAYS; w++)
					if (dead_wr[2*w +: 2] < 2'(DEAD_TOP)) dead_wr[2*w +: 2] += 2'd1;
			if (hit_flag) begin
				if (leader_s && duel_q != DMAX) duel_d = duel_q + 1'b1;
				else if (leader_b && duel_q != '0) duel_d = duel_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR) begin
			rrpv_mem[clr_q] <= {NUM_WAYS{2'd3}};
			dead_mem[clr_q] <= {NUM_WAYS{2'd1}};
			strm_mem[clr_q] <= '0;
		end else if (wr_en) begin
			rrpv_mem[set_w] <= rrpv_wr;
			dead_mem[set_w] <= dead_wr;
			if (op == OP_UPDATE) strm_mem[set_w] <= strm_wr;
		end
		rrpv_rd_q <= rrpv_mem[set_w];
		dead_rd_q <= dead_mem[set_w];
		strm_rd_q <= strm_mem[set_w];
		if (state_q == BK_WRITE) begin
			vw_q <= (op == OP_VICTIM) ? 4'(vic) : 4'd0;
			st_q <= (op == OP_UPDATE) && st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			duel_q  <= DMAX >> 1;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == BK_WRITE) begin
				duel_q <= duel_d;
				ov_q   <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid      = ov_q;
	assign victim_way     = vw_q;
	assign streaming      = st_q;
	assign selector_value = 10'(duel_q);
endmodule

### rtl/drrip_stream_dead_block_replacement.sv
// Top level of the DRRIP replacement metadata block with stream and dead-block bias.
//  channel | direction | handshake                 | payload
//  cfg     | in        | cfg_we                    | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready       | op .. random_draw
//  out     | out       | out_valid / out_ready     | victim_way, streaming, selector_value
// Each transaction steps through the back end in order: memory read, row rewrite, idle.
// After reset a clearing pass over all NUM_SETS sets initializes the set memories;
// transactions queue in the front (two deep) but none is processed until it ends.
// The back end holds when the result register is full and not taken.
`timescale 1ns / 1ps
module drrip_stream_dead_block_replacement #(
	parameter int NUM_SETS    = 2048,
	parameter int NUM_WAYS    = 16,
	parameter int LEADER_SETS = 32,
	parameter int DUEL_WIDTH  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [10:0] set_index,
	input  logic [3:0]  way_index,
	input  logic [15:0] addr_lsbs,
	input  logic        hit_flag,
	input  logic        victim_valid,
	input  logic [4:0]  random_draw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  victim_way,
	output logic        streaming,
	output logic [9:0]  selector_value
);
	import drrip_pkg::*;

	logic [2:0] slen_q;
	logic [1:0] dthr_q;
	logic q_valid, q_pop;
	logic [38:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slen_q <= 3'd4;
			dthr_q <= 2'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STREAM_LENGTH:  slen_q <= cfg_data;
				CFG_DEAD_THRESHOLD: dthr_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	drrip_front #(.W(39)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_data({op, set_index, way_index, addr_lsbs, hit_flag, victim_valid, random_draw}),
		.q_valid, .q_pop, .q_data
	);

	drrip_back #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
		.LEADER_SETS(LEADER_SETS), .DUEL_WIDTH(DUEL_WIDTH)
	) u_back (
		.clk, .arst_n, .q_valid, .q_pop,
		.op(q_data[38]), .set_index(q_data[37:27]), .way_index(q_data[26:23]),
		.addr_lsbs(q_data[22:7]), .hit_flag(q_data[6]), .victim_valid(q_data[5]),
		.random_draw(q_data[4:0]),
		.stream_len(slen_q), .dead_thr(dthr_q),
		.out_valid, .out_ready, .victim_way, .streaming, .selector_value
	);
endmodule

### dv/tb.sv
// Self-checking testbench for the DRRIP stream/dead-block replacement block.
`timescale 1ns / 1ps
module tb;
	import drrip_pkg::*;

	localparam int SETS = 2048;
	localparam int WAYS = 16;
	localparam int LEADERS = 32;
	localparam int SEL_MAX = 1023;

	typedef struct packed {
		logic        op;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic [15:0] addr_lsbs;
		logic        hit_flag;
		logic        victim_valid;
		logic [4:0]  random_draw;
	} access_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       streaming;
		logic [9:0] selector_value;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [2:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	access_t cur = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [3:0] victim_way;
	logic streaming;
	logic [9:0] selector_value;

	always #1 clk = ~clk;

	drrip_stream_dead_block_replacement uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.op(cur.op), .set_index(cur.set_index), .way_index(cur.way_index),
		.addr_lsbs(cur.addr_lsbs), .hit_flag(cur.hit_flag),
		.victim_valid(cur.victim_valid), .random_draw(cur.random_draw),
		.out_valid(out_valid), .out_ready(out_ready), .victim_way(victim_way),
		.streaming(streaming), .selector_value(selector_value)
	);

	// shadow of the replacement metadata
	logic [1:0]  rrpv_mem [SETS*WAYS];
	logic [1:0]  dead_mem [SETS*WAYS];
	logic [15:0] last_addr [SETS];
	logic [15:0] last_stride [SETS];
	logic [2:0]  run_len [SETS];
	int unsigned psel;
	int unsigned run_needed;
	int unsigned dead_limit;

	access_t  pending_q[$];
	verdict_t expected_q[$];
	int errors = 0;
	int checked = 0;
	int launched = 0;
	int n_stream = 0;
	int n_victim = 0;

	function automatic logic [1:0] duel_insert(int unsigned s, logic [4:0] draw);
		logic [1:0] br;
		br = (draw == 0) ? 2'd2 : 2'd3;
		if (s < LEADERS/2) return 2'd2;
		if (s < LEADERS) return br;
		return (psel >= SEL_MAX/2) ? br : 2'd2;
	endfunction

	function automatic verdict_t predict_replacement(access_t a);
		verdict_t r;
		int unsigned s, b, top, i;
		logic [15:0] stride;
		logic st;
		r = '0;
		s = 32'(a.set_index);
		b = s * WAYS;
		if (a.op == OP_VICTIM) begin
			top = 0;
			for (int w = 0; w < WAYS; w++)
				if (rrpv_mem[b+w] > top) top = 32'(rrpv_mem[b+w]);
			for (int w = WAYS-1; w >= 0; w--)
				if (rrpv_mem[b+w] == top) r.victim_way = 4'(w);
			for (int w = 0; w < WAYS; w++)
				rrpv_mem[b+w] = 2'(rrpv_mem[b+w] + (RRPV_TOP - top));
		end else begin
			stride = a.addr_lsbs - last_addr[s];
			st = 0;
			if (run_len[s] != 0 && stride == last_stride[s] && stride != 0) begin
				if (run_len[s] < RUN_TOP) run_len[s]++;
				st = (run_len[s] >= run_needed);
			end else begin
				last_stride[s] = stride;
				run_len[s] = 3'd1;
			end
			last_addr[s] = a.addr_lsbs;
			r.streaming = st;
			i = b + 32'(a.way_index);
			if (!a.hit_flag) begin
				if (st || dead_mem[i] >= dead_limit) rrpv_mem[i] = 2'(RRPV_TOP);
				else rrpv_mem[i] = duel_insert(s, a.random_draw);
				dead_mem[i] = 2'd1;
				if (a.victim_valid)
					for (int w = 0; w < WAYS; w++)
						if (dead_mem[b+w] < DEAD_TOP) dead_mem[b+w]++;
			end else begin
				rrpv_mem[i] = 2'd0;
				if (dead_mem[i] > 0) dead_mem[i]--;
				if (s < LEADERS/2) begin
					if (psel < SEL_MAX) psel++;
				end else if (s < LEADERS) begin
					if (psel > 0) psel--;
				end
			end
		end
		r.selector_value = 10'(psel);
		return r;
	endfunction

	// driver: bursts and gaps
	int gap_left = 0;
	int burst_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_q.push_back(predict_replacement(cur));
				if (cur.op == OP_VICTIM) n_victim++;
			end
			if ((!in_valid || in_ready) ) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 0;
				end else if (pending_q.size() > 0) begin
					cur <= pending_q.pop_front();
					launched++;
					in_valid <= 1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor and receiver stall pattern
	logic [15:0] stall_pat = 16'hffff;
	int stall_ph = 0;
	always @(posedge clk) begin
		verdict_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				checked++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction");
				end else begin
					exp_r = expected_q.pop_front();
					if (streaming) n_stream++;
					if (victim_way !== exp_r.victim_way || streaming !== exp_r.streaming
						|| selector_value !== exp_r.selector_value) begin
						errors++;
						if (errors <= 10)
							$display("mismatch #%0d: exp way=%0d str=%0d sel=%0d got %0d %0d %0d",
								checked, exp_r.victim_way, exp_r.streaming,
								exp_r.selector_value, victim_way, streaming, selector_value);
					end
				end
			end
			stall_ph <= (stall_ph + 1) % 16;
			if (stall_ph == 15 && $urandom_range(0, 3) == 0)
				stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
			out_ready <= stall_pat[stall_ph];
		end
	end

	task automatic add_item(logic op, int s, int w, int addr, logic hit, logic vv, int draw);
		access_t a;
		a.op = op; a.set_index = 11'(s); a.way_index = 4'(w); a.addr_lsbs = 16'(addr);
		a.hit_flag = hit; a.victim_valid = vv; a.random_draw = 5'(draw);
		pending_q.push_back(a);
	endtask

	task automatic drain;
		while (pending_q.size() > 0 || checked < launched) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= 3'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_STREAM_LENGTH) run_needed = val; else dead_limit = val;
	endtask

	task automatic random_phase(int count);
		int s, base, stride;
		while (count > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// strided run in one set
					s = ($urandom_range(0, 1)) ? $urandom_range(0, 63) : $urandom_range(0, SETS-1);
					base = $urandom; stride = $urandom_range(1, 3) * 64;
					if ($urandom_range(0, 7) == 0) stride = $urandom;
					for (int k = 0; k < $urandom_range(3, 10) && count > 0; k++) begin
						add_item(OP_UPDATE, s, $urandom, base + k*stride, $urandom_range(0, 3) == 0,
							$urandom, $urandom_range(0, 1) ? 0 : $urandom);
						count--;
					end
				end
				3, 4: begin
					s = $urandom_range(0, 47);
					add_item(OP_UPDATE, s, $urandom, $urandom, 1, $urandom, $urandom);
					count--;
				end
				5, 6: begin
					s = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, SETS-1);
					add_item(OP_VICTIM, s, $urandom, $urandom, $urandom, $urandom, $urandom);
					add_item(OP_UPDATE, s, $urandom, $urandom, 0, $urandom, $urandom);
					count -= 2;
				end
				default: begin
					add_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
					count--;
				end
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < SETS*WAYS; i++) begin
			rrpv_mem[i] = 3; dead_mem[i] = 1;
		end
		for (int i = 0; i < SETS; i++) begin
			last_addr[i] = 0; last_stride[i] = 0; run_len[i] = 0;
		end
		psel = SEL_MAX/2; run_needed = 4; dead_limit = 2;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, stream detection, leaders, victim aging
		add_item(OP_VICTIM, 0, 0, 0, 0, 0, 0);
		add_item(OP_VICTIM, 2047, 15, 16'hffff, 1, 1, 31);
		for (int k = 0; k < 6; k++)
			add_item(OP_UPDATE, 5, k, 16'hfff0 + k*16, 0, 1, 0);
		add_item(OP_UPDATE, 5, 15, 16'hfff0, 0, 0, 0);
		add_item(OP_UPDATE, 5, 15, 16'hfff0, 0, 0, 0);
		add_item(OP_UPDATE, 3, 2, 100, 1, 0, 0);
		add_item(OP_UPDATE, 20, 2, 100, 1, 0, 0);
		add_item(OP_UPDATE, 20, 3, 200, 0, 0, 0);
		add_item(OP_UPDATE, 20, 4, 300, 0, 1, 7);
		add_item(OP_UPDATE, 1000, 7, 400, 0, 0, 31);
		add_item(OP_UPDATE, 1000, 7, 400, 1, 0, 0);
		add_item(OP_VICTIM, 5, 0, 0, 0, 0, 0);
		add_item(OP_VICTIM, 20, 0, 0, 0, 0, 0);
		add_item(OP_VICTIM, 1000, 0, 0, 0, 0, 0);
		add_item(OP_VICTIM, 1000, 0, 0, 0, 0, 0);
		drain();

		write_reg(CFG_STREAM_LENGTH, 2);
		write_reg(CFG_DEAD_THRESHOLD, 1);
		random_phase(300);
		drain();
		write_reg(CFG_STREAM_LENGTH, 7);
		write_reg(CFG_DEAD_THRESHOLD, 3);
		random_phase(300);
		drain();
		write_reg(CFG_STREAM_LENGTH, $urandom_range(0, 1));
		write_reg(CFG_DEAD_THRESHOLD, 0);
		random_phase(150);
		drain();
		write_reg(CFG_STREAM_LENGTH, 4);
		write_reg(CFG_DEAD_THRESHOLD, 2);
		random_phase(150);
		drain();

		$display("checked %0d results: %0d victim requests, %0d streaming updates, %0d errors",
			checked, n_victim, n_stream, errors);
		if (errors == 0)
			$display("drrip_stream_dead_block_replacement test passed");
		else
			$display("drrip_stream_dead_block_replacement test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("drrip_stream_dead_block_replacement test failed");
		$finish;
	end
endmodule

### drrip_stream_dead_block_replacement.f
rtl/drrip_pkg.sv
rtl/drrip_front.sv
rtl/drrip_back.sv
rtl/drrip_stream_dead_block_replacement.sv
dv/tb.sv
